[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helpers for the patch apply block.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Width of old-file positions and run counters
  localparam int unsigned POS_BITS    = 32;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned WIDE_BITS   = (POS_BITS > ADDR_BITS) ? POS_BITS : ADDR_BITS;
  localparam int unsigned RAW_BITS    = 64;
  localparam int unsigned BYTE_BITS   = 8;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result kind
  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_BYTE = 1'b1
  } kind_e;

  // Input operation
  typedef enum logic {
    OP_TRIPLE = 1'b0,
    OP_DATA   = 1'b1
  } op_e;

  // Result status
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_STRAY   = 3'd3,
    ST_POS     = 3'd4
  } status_e;

  // Where the back end takes the output byte from
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_MIX  = 2'd1,
    SRC_COPY = 2'd2
  } src_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    src_e                  src;
    logic [BYTE_BITS-1:0]  byte_a;
    logic [BYTE_BITS-1:0]  byte_b;
    logic [ADDR_BITS-1:0]  addr;
    logic                  last;
  } cmd_t;

  // Position to reported address: zero-extend or truncate
  function automatic logic [ADDR_BITS-1:0] pos_to_addr(input logic [POS_BITS-1:0] pos);
    logic [WIDE_BITS-1:0] wide;
    wide = WIDE_BITS'(pos);
    return wide[ADDR_BITS-1:0];
  endfunction

endpackage

[rtl/bpa_front.sv]
// ----------------------------------------------------------------------------
// bpa_front
// Accepts items, decodes control triples and tracks run counters and the
// old-file position; emits one classified command per accepted item.
// ----------------------------------------------------------------------------
module bpa_front import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 operation_i,
  input  logic [RAW_BITS-1:0]  mix_length_raw_i,
  input  logic [RAW_BITS-1:0]  copy_length_raw_i,
  input  logic [RAW_BITS-1:0]  seek_length_raw_i,
  input  logic [BYTE_BITS-1:0] diff_byte_i,
  input  logic [BYTE_BITS-1:0] old_byte_i,
  input  logic [BYTE_BITS-1:0] extra_byte_i,
  output cmd_t                 cmd_o
);

  localparam int unsigned P = POS_BITS;
  localparam logic [P+1:0] LIMIT = {2'b01, {P{1'b0}}};

  logic [P-1:0] mix_left_q, mix_left_d;
  logic [P-1:0] copy_left_q, copy_left_d;
  logic [P-1:0] old_pos_q, old_pos_d;
  logic [P-1:0] next_pos_q, next_pos_d;

  // Sign-magnitude decode of the triple
  logic         mix_neg, mix_big, copy_neg, copy_big, seek_neg, seek_big;
  logic [P-1:0] mix_mag, copy_mag;
  logic [P:0]   seek_lo;
  logic [P+1:0] base, seek_ext, pos_sum, pos_diff, new_pos;
  logic         pos_fail, busy;

  assign mix_neg  = mix_length_raw_i[RAW_BITS-1] & (|mix_length_raw_i[RAW_BITS-2:0]);
  assign mix_big  = |mix_length_raw_i[RAW_BITS-2:P];
  assign mix_mag  = mix_length_raw_i[P-1:0];
  assign copy_neg = copy_length_raw_i[RAW_BITS-1] & (|copy_length_raw_i[RAW_BITS-2:0]);
  assign copy_big = |copy_length_raw_i[RAW_BITS-2:P];
  assign copy_mag = copy_length_raw_i[P-1:0];
  assign seek_neg = seek_length_raw_i[RAW_BITS-1] & (|seek_length_raw_i[RAW_BITS-2:0]);
  // anything above bit P of the seek always leaves the range
  assign seek_big = |seek_length_raw_i[RAW_BITS-2:P+1];
  assign seek_lo  = seek_length_raw_i[P:0];

  // New position: old position plus mix, then the signed seek
  assign base     = {2'b00, old_pos_q} + {2'b00, mix_mag};
  assign seek_ext = {1'b0, seek_lo};
  assign pos_sum  = base + seek_ext;
  assign pos_diff = base - seek_ext;
  assign new_pos  = seek_neg ? pos_diff : pos_sum;
  assign pos_fail = (base > LIMIT) | seek_big | (seek_neg & (seek_ext > base))
                  | (new_pos >= LIMIT);

  assign busy = (mix_left_q != '0) || (copy_left_q != '0);

  // Classify the item and work out the next state
  always_comb begin
    mix_left_d  = mix_left_q;
    copy_left_d = copy_left_q;
    old_pos_d   = old_pos_q;
    next_pos_d  = next_pos_q;
    cmd_o        = '0;
    cmd_o.byte_a = '0;
    cmd_o.byte_b = '0;
    if (operation_i == OP_TRIPLE) begin
      cmd_o.kind = KIND_ACK;
      cmd_o.src  = SRC_NONE;
      cmd_o.addr = pos_to_addr(old_pos_q);
      priority if (busy) begin
        cmd_o.status = ST_OVERLAP;
      end else if (mix_neg || mix_big || copy_neg || copy_big) begin
        cmd_o.status = ST_BAD_LEN;
      end else if (pos_fail) begin
        cmd_o.status = ST_POS;
      end else begin
        cmd_o.status = ST_OK;
        cmd_o.last   = (mix_mag == '0) && (copy_mag == '0);
        mix_left_d   = mix_mag;
        copy_left_d  = copy_mag;
        next_pos_d   = new_pos[P-1:0];
        if (mix_mag == '0) begin
          old_pos_d = new_pos[P-1:0];
        end
      end
    end else begin
      cmd_o.kind = KIND_BYTE;
      priority if (mix_left_q != '0) begin
        cmd_o.status = ST_OK;
        cmd_o.src    = SRC_MIX;
        cmd_o.byte_a = old_byte_i;
        cmd_o.byte_b = diff_byte_i;
        cmd_o.addr   = pos_to_addr(old_pos_q);
        cmd_o.last   = (mix_left_q == P'(1)) && (copy_left_q == '0);
        mix_left_d   = mix_left_q - P'(1);
        // seek takes effect once the mix run ends
        old_pos_d    = (mix_left_q == P'(1)) ? next_pos_q : old_pos_q + P'(1);
      end else if (copy_left_q != '0) begin
        cmd_o.status = ST_OK;
        cmd_o.src    = SRC_COPY;
        cmd_o.byte_a = extra_byte_i;
        cmd_o.last   = (copy_left_q == P'(1));
        copy_left_d  = copy_left_q - P'(1);
      end else begin
        cmd_o.status = ST_STRAY;
        cmd_o.src    = SRC_NONE;
      end
    end
  end

  // Run counters and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_left_q  <= '0;
      copy_left_q <= '0;
      old_pos_q   <= '0;
      next_pos_q  <= '0;
    end else if (accept_i) begin
      mix_left_q  <= mix_left_d;
      copy_left_q <= copy_left_d;
      old_pos_q   <= old_pos_d;
      next_pos_q  <= next_pos_d;
    end
  end

endmodule

[rtl/bpa_fifo.sv]
// ----------------------------------------------------------------------------
// bpa_fifo
// Short queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module bpa_fifo import bpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output cmd_t rd_data_o
);

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;

  assign full_o    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/bpa_back.sv]
// ----------------------------------------------------------------------------
// bpa_back
// Carries out queued commands: forms the output byte and holds the result
// item in an output register until it is popped.
// ----------------------------------------------------------------------------
module bpa_back import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  cmd_t                 q_data_i,
  output logic                 q_rd_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic                 kind_o,
  output logic [2:0]           status_o,
  output logic [BYTE_BITS-1:0] patched_byte_o,
  output logic [ADDR_BITS-1:0] old_address_o,
  output logic                 last_o
);

  logic                 valid_q;
  logic                 kind_q, kind_d;
  logic [2:0]           status_q, status_d;
  logic [BYTE_BITS-1:0] byte_q, byte_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic                 last_q, last_d;

  // Refill the output register when it is free or being popped
  assign q_rd_o = !q_empty_i && (!valid_q || pop_i);

  // Byte formation
  always_comb begin
    kind_d   = q_data_i.kind;
    status_d = q_data_i.status;
    addr_d   = q_data_i.addr;
    last_d   = q_data_i.last;
    unique case (q_data_i.src)
      SRC_MIX:  byte_d = q_data_i.byte_a + q_data_i.byte_b;
      SRC_COPY: byte_d = q_data_i.byte_a;
      default:  byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      byte_q   <= byte_d;
      addr_q   <= addr_d;
      last_q   <= last_d;
    end
  end

  assign empty_o        = !valid_q;
  assign kind_o         = kind_q;
  assign status_o       = status_q;
  assign patched_byte_o = byte_q;
  assign old_address_o  = addr_q;
  assign last_o         = last_q;

endmodule

[rtl/binary_patch_apply_top.sv]
// Path: an accepted item is written into the queue, then read into the output
// register, from which its result is popped; one result per input item.
// Throughput: one item per cycle while not full; counter/position update is the
// front's feedback loop; the four-entry queue and output register absorb stalls.
// Reset: asynchronous, active low; clears run counters, positions, queue
// pointers and the output valid flag at once, no clearing pass.
// ----------------------------------------------------------------------------
// binary_patch_apply_top
// Applies a patch stream of control triples and data items.
// ----------------------------------------------------------------------------
module binary_patch_apply_top import bpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation_i,
  input  logic [RAW_BITS-1:0]  mix_length_raw_i,
  input  logic [RAW_BITS-1:0]  copy_length_raw_i,
  input  logic [RAW_BITS-1:0]  seek_length_raw_i,
  input  logic [BYTE_BITS-1:0] diff_byte_i,
  input  logic [BYTE_BITS-1:0] old_byte_i,
  input  logic [BYTE_BITS-1:0] extra_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind_o,
  output logic [2:0]           status_o,
  output logic [BYTE_BITS-1:0] patched_byte_o,
  output logic [ADDR_BITS-1:0] old_address_o,
  output logic                 last_o
);

  logic accept;
  cmd_t front_cmd, q_cmd;
  logic q_empty, q_rd;

  assign accept = push && !full;

  // Front: decode and classify
  bpa_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .mix_length_raw_i  (mix_length_raw_i),
    .copy_length_raw_i (copy_length_raw_i),
    .seek_length_raw_i (seek_length_raw_i),
    .diff_byte_i       (diff_byte_i),
    .old_byte_i        (old_byte_i),
    .extra_byte_i      (extra_byte_i),
    .cmd_o             (front_cmd)
  );

  // Queue between the two sides
  bpa_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (q_cmd)
  );

  // Back: byte formation and output register
  bpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_cmd),
    .q_rd_o         (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .patched_byte_o (patched_byte_o),
    .old_address_o  (old_address_o),
    .last_o         (last_o)
  );

`ifndef ASSERT_OFF
  // status codes stay within the defined set
  a_status_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o <= ST_POS))
    else $error("status out of range");

  // acknowledgements never carry a data byte
  a_ack_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_ACK) |-> (patched_byte_o == '0))
    else $error("acknowledgement with byte");

  // a failed item never closes a run
  a_err_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> !last_o)
    else $error("error item marked last");

  // stray data reports neither byte nor address
  a_stray_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_STRAY) |-> (kind_o == KIND_BYTE && patched_byte_o == '0
                                          && old_address_o == '0))
    else $error("stray data item not clean");
`endif

endmodule
